>>> design/assert_macros.svh
// Assertion macros used by the list RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/iil_pkg.sv
// Types and constants for the indexed insert list.
package iil_pkg;

  localparam int IIL_DEPTH = 16;
  localparam int DATA_W    = 32;
  localparam int REQ_W     = 3;
  localparam int POS_W     = 5;
  localparam int STAT_W    = 2;
  localparam int ECNT_W    = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_BACK  = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_INSERT     = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_POP_FRONT  = 3'd4,
    REQ_READ       = 3'd5
  } req_kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // What every cell does in a cycle.
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_INSERT,
    CMD_REMOVE_FRONT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
  } cell_ctl_t;

endpackage

>>> design/iil_if.sv
// Request and response channel interfaces of the list.
interface iil_req_if import iil_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [DATA_W-1:0] value;
  logic [POS_W-1:0]         position;

  modport source (output valid, output req_type, output value, output position,
                  input ready);
  modport sink   (input valid, input req_type, input value, input position,
                  output ready);
endinterface

interface iil_rsp_if import iil_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic [ECNT_W-1:0]        entry_count;
  logic signed [DATA_W-1:0] read_value;

  modport source (output valid, output status, output entry_count,
                  output read_value, input ready);
  modport sink   (input valid, input status, input entry_count,
                  input read_value, output ready);
endinterface

>>> design/iil_cell.sv
// One list slot: holds an entry and takes from its neighbors on shifts.
module iil_cell import iil_pkg::*; #(
  parameter int CNT_W = $clog2(IIL_DEPTH + 1),
  parameter int IDX   = 0
) (
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic [CNT_W-1:0]         pos,
  input  logic signed [DATA_W-1:0] value,
  input  logic signed [DATA_W-1:0] left,
  input  logic signed [DATA_W-1:0] right,
  output logic signed [DATA_W-1:0] entry
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  // Insert: slot at pos takes the new value, slots above take from the left.
  // Remove front: every slot takes from the right.
  always_ff @(posedge clk) begin
    case (ctl.kind)
      CMD_INSERT: begin
        if (MY_IDX == pos) begin
          entry <= value;
        end else if (MY_IDX > pos) begin
          entry <= left;
        end
      end
      CMD_REMOVE_FRONT: begin
        entry <= right;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> design/indexed_insert_list.sv
// Indexed insert list: an ordered list of up to DEPTH signed 32-bit entries
// kept in a row of cells, one entry per cell. Push back, push front, insert
// at a position, pop back, pop front and read each complete on acceptance:
// an insert or pop front shifts cells toward or away from their neighbors,
// a pop back changes only the entry count and a read changes nothing. A
// request is taken in every cycle in which no response is held or the held
// response is being taken, and its response appears in the output register
// in the cycle after acceptance. A request that would overflow, underflow
// or address past the count changes nothing and reports full, empty or
// out-of-range status. entry_count reports the low five bits of the count.
module indexed_insert_list import iil_pkg::*; #(
  parameter int DEPTH = IIL_DEPTH
) (
  input logic       clk,
  input logic       rst,
  iil_req_if.sink   req,
  iil_rsp_if.source rsp
);

  `include "assert_macros.svh"

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic                     out_valid;
  logic [STAT_W-1:0]        out_status;
  logic [ECNT_W-1:0]        out_count;
  logic signed [DATA_W-1:0] out_value;

  logic                     acc;
  logic                     full;
  logic                     empty;
  logic [CMP_W-1:0]         pos_w;
  logic [CMP_W-1:0]         cnt_w;
  status_t                  status_next;
  cmd_kind_t                cmd_kind;
  logic [CNT_W-1:0]         ins_pos;
  logic signed [DATA_W-1:0] rd_next;
  cell_ctl_t                cell_ctl;
  logic signed [DATA_W-1:0] cell_val [DEPTH];

  assign acc       = req.valid && req.ready;
  assign req.ready = !out_valid || rsp.ready;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign pos_w = CMP_W'(req.position);
  assign cnt_w = CMP_W'(count);

  // Request decode and status
  always_comb begin
    status_next = ST_OK;
    count_next  = count;
    cmd_kind    = CMD_NONE;
    ins_pos     = count;
    rd_next     = '0;
    case (req.req_type)
      REQ_PUSH_BACK: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          cmd_kind   = CMD_INSERT;
          ins_pos    = count;
          count_next = count + CNT_W'(1);
        end
      end
      REQ_PUSH_FRONT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          cmd_kind   = CMD_INSERT;
          ins_pos    = '0;
          count_next = count + CNT_W'(1);
        end
      end
      REQ_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else if (pos_w > cnt_w) begin
          status_next = ST_RANGE;
        end else begin
          cmd_kind   = CMD_INSERT;
          ins_pos    = pos_w[CNT_W-1:0];
          count_next = count + CNT_W'(1);
        end
      end
      REQ_POP_BACK: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          count_next = count - CNT_W'(1);
        end
      end
      REQ_POP_FRONT: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          cmd_kind   = CMD_REMOVE_FRONT;
          count_next = count - CNT_W'(1);
        end
      end
      REQ_READ: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          status_next = ST_RANGE;
        end else begin
          rd_next = cell_val[pos_w[IDX_W-1:0]];
        end
      end
      default: begin
      end
    endcase
  end

  assign cell_ctl.kind = acc ? cmd_kind : CMD_NONE;

  // Row of cells; each end sees the request value or itself as neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_val;
    logic signed [DATA_W-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_val = req.value;
    end else begin : g_inner_l
      assign left_val = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_inner_r
      assign right_val = cell_val[i+1];
    end

    iil_cell #(
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk   (clk),
      .ctl   (cell_ctl),
      .pos   (ins_pos),
      .value (req.value),
      .left  (left_val),
      .right (right_val),
      .entry (cell_val[i])
    );
  end

  // Count and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (acc) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    if (acc) begin
      out_status <= status_next;
      out_count  <= ECNT_W'(count_next);
      out_value  <= rd_next;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.entry_count = out_count;
  assign rsp.read_value  = out_value;

  `ASSERT_CLK(a_count_bound, count <= CNT_W'(DEPTH), "count exceeds depth")
  `ASSERT_CLK(a_insert_grows, acc && cmd_kind == CMD_INSERT |=> count == $past(count) + CNT_W'(1), "insert did not grow count")
  `ASSERT_CLK(a_error_holds, acc && status_next != ST_OK |=> $stable(count), "failed request changed count")
  `ASSERT_CLK(a_resp_follows, acc |=> rsp.valid, "no response after accepted request")

endmodule
